/* rtl/mono_glyph_color_expand_assert.svh */
// Assertion macros for the glyph expander.
`ifndef MONO_GLYPH_COLOR_EXPAND_ASSERT_SVH
`define MONO_GLYPH_COLOR_EXPAND_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define MGCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mgce assertion failed");

// Next-cycle implication, disabled while in reset.
`define MGCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mgce assertion failed");

`endif

/* rtl/mgce_pkg.sv */
package mgce_pkg;

    localparam int MAX_GLYPH_WIDTH   = 16;
    localparam int ADDRESS_BITS_DEF  = 32;
    localparam int ROW_BITS          = 16;
    localparam int QUEUE_DEPTH       = 4;

    typedef enum logic [2:0] {
        REG_FG_COLOR,
        REG_BG_COLOR,
        REG_PIXEL_FORMAT,
        REG_LINE_PITCH,
        REG_FRAME_BASE,
        REG_GLYPH_WIDTH,
        REG_GLYPH_HEIGHT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FMT_RGB332,
        FMT_RGB555,
        FMT_RGB565,
        FMT_RGB888
    } pix_fmt_t;

    localparam logic [23:0] FG_RESET    = 24'hffffff;
    localparam logic [23:0] BG_RESET    = 24'h000000;
    localparam logic [14:0] PITCH_RESET = 15'd3072;
    localparam logic [31:0] BASE_RESET  = 32'h0;
    localparam logic [4:0]  WIDTH_RESET = 5'd8;
    localparam logic [5:0]  HEIGHT_RESET = 6'd16;

    typedef struct packed {
        logic [23:0] fg_color;
        logic [23:0] bg_color;
        pix_fmt_t    pixel_format;
        logic [14:0] line_pitch;
        logic [31:0] frame_base;
        logic [4:0]  glyph_width;
        logic [5:0]  glyph_height;
    } cfg_t;

    // One glyph row as handed from front to back (address travels separately).
    typedef struct packed {
        logic [ROW_BITS-1:0] bits;
        logic [3:0]          width_m1;
        logic                last_row;
    } row_info_t;

    typedef struct packed {
        logic full;
        logic valid;
    } q_status_t;

    function automatic logic [1:0] bytes_per_pixel(input pix_fmt_t fmt);
        logic [1:0] bpp;
        case (fmt)
            FMT_RGB332: bpp = 2'd1;
            FMT_RGB555: bpp = 2'd2;
            FMT_RGB565: bpp = 2'd2;
            FMT_RGB888: bpp = 2'd3;
            default:    bpp = 2'd3;
        endcase
        return bpp;
    endfunction

    function automatic logic [23:0] pack_color(input pix_fmt_t fmt, input logic [23:0] c);
        logic [23:0] p;
        case (fmt)
            FMT_RGB332: p = {16'h0, c[23:21], c[15:14], 1'b0, c[7:6]};
            FMT_RGB555: p = {8'h0, 1'b0, c[23:19], c[15:11], c[7:3]};
            FMT_RGB565: p = {8'h0, c[23:19], c[15:10], c[7:3]};
            FMT_RGB888: p = c;
            default:    p = c;
        endcase
        return p;
    endfunction

endpackage

/* rtl/mgce_front.sv */
module mgce_front
    import mgce_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic                    first_row,
    input  logic [11:0]             dest_x,
    input  logic [11:0]             dest_y,
    input  logic [ROW_BITS-1:0]     row_bits,
    input  q_status_t               q_status,
    output logic                    push,
    output logic [ADDRESS_BITS-1:0] push_addr,
    output row_info_t               push_info
);

    localparam int WIDTH_CAP = (MAX_GLYPH_WIDTH < ROW_BITS) ? MAX_GLYPH_WIDTH : ROW_BITS;

    logic [ADDRESS_BITS-1:0] row_address_reg, row_address_next;
    logic [4:0]              row_index_reg, row_index_next;

    logic [1:0]              bpp;
    logic [26:0]             pitch_y;
    logic [13:0]             bpp_x;
    logic [ADDRESS_BITS-1:0] first_addr;
    logic [ADDRESS_BITS-1:0] addr;
    logic [4:0]              idx;
    logic [5:0]              height;
    logic [4:0]              width;
    logic                    last_row;

    assign item_stall = q_status.full;
    assign push       = item_valid && !q_status.full;

    always_comb
    begin
        bpp        = bytes_per_pixel(cfg.pixel_format);
        pitch_y    = 27'(cfg.line_pitch) * 27'(dest_y);
        bpp_x      = 14'(bpp) * 14'(dest_x);
        first_addr = ADDRESS_BITS'(cfg.frame_base) + ADDRESS_BITS'(pitch_y)
                   + ADDRESS_BITS'(bpp_x);

        width = cfg.glyph_width;
        if (width == 5'd0)
        begin
            width = 5'd1;
        end
        if (width > 5'(WIDTH_CAP))
        begin
            width = 5'(WIDTH_CAP);
        end

        height = cfg.glyph_height;
        if (height == 6'd0)
        begin
            height = 6'd1;
        end
        if (height > 6'd32)
        begin
            height = 6'd32;
        end

        if (first_row)
        begin
            addr = first_addr;
            idx  = 5'd0;
        end
        else
        begin
            addr = row_address_reg;
            idx  = row_index_reg;
        end

        last_row = ({1'b0, idx} + 6'd1) >= height;

        row_address_next = addr + ADDRESS_BITS'(cfg.line_pitch);
        row_index_next   = last_row ? 5'd0 : idx + 5'd1;

        push_addr          = addr;
        push_info.bits     = row_bits;
        push_info.width_m1 = 4'(width - 5'd1);
        push_info.last_row = last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_address_reg <= '0;
            row_index_reg   <= '0;
        end
        else if (push)
        begin
            row_address_reg <= row_address_next;
            row_index_reg   <= row_index_next;
        end
    end

endmodule

/* rtl/mgce_queue.sv */
module mgce_queue
    import mgce_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  logic [ADDRESS_BITS-1:0] push_addr,
    input  row_info_t               push_info,
    input  logic                    pop,
    output logic [ADDRESS_BITS-1:0] head_addr,
    output row_info_t               head_info,
    output q_status_t               q_status
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [ADDRESS_BITS-1:0] addr_mem [QUEUE_DEPTH];
    row_info_t               info_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign q_status.full  = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_status.valid = count_reg != '0;
    assign do_pop         = pop && q_status.valid;

    assign head_addr = addr_mem[rd_ptr_reg];
    assign head_info = info_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            addr_mem[wr_ptr_reg] <= push_addr;
            info_mem[wr_ptr_reg] <= push_info;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/mgce_back.sv */
module mgce_back
    import mgce_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cfg_t                    cfg,
    input  q_status_t               q_status,
    input  logic [ADDRESS_BITS-1:0] head_addr,
    input  row_info_t               head_info,
    output logic                    pop,
    output logic                    pix_valid,
    input  logic                    pix_stall,
    output logic [31:0]             pixel_address,
    output logic [23:0]             pixel_data,
    output logic [1:0]              byte_count,
    output logic                    row_end,
    output logic                    glyph_end
);

    // Current row being walked
    logic                    busy_reg, busy_next;
    logic [ADDRESS_BITS-1:0] addr_reg, addr_next;
    logic [ROW_BITS-1:0]     bits_reg, bits_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [3:0]              wm1_reg, wm1_next;
    logic                    last_row_reg, last_row_next;

    // Output stage
    logic                    ovalid_reg, ovalid_next;
    logic [ADDRESS_BITS-1:0] oaddr_reg, oaddr_next;
    logic [23:0]             odata_reg, odata_next;
    logic [1:0]              obytes_reg, obytes_next;
    logic                    orow_end_reg, orow_end_next;
    logic                    oglyph_end_reg, oglyph_end_next;

    logic       out_free;
    logic       emit;
    logic       last_pix;
    logic [1:0] bpp;

    assign bpp      = bytes_per_pixel(cfg.pixel_format);
    assign out_free = !ovalid_reg || !pix_stall;
    assign emit     = busy_reg && out_free;
    assign last_pix = cnt_reg == wm1_reg;
    assign pop      = q_status.valid && (!busy_reg || (emit && last_pix));

    always_comb
    begin
        busy_next     = busy_reg;
        addr_next     = addr_reg;
        bits_next     = bits_reg;
        cnt_next      = cnt_reg;
        wm1_next      = wm1_reg;
        last_row_next = last_row_reg;
        if (pop)
        begin
            busy_next     = 1'b1;
            addr_next     = head_addr;
            bits_next     = head_info.bits;
            cnt_next      = 4'd0;
            wm1_next      = head_info.width_m1;
            last_row_next = head_info.last_row;
        end
        else if (emit)
        begin
            addr_next = addr_reg + ADDRESS_BITS'(bpp);
            bits_next = {bits_reg[ROW_BITS-2:0], 1'b0};
            cnt_next  = cnt_reg + 4'd1;
            if (last_pix)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        ovalid_next     = ovalid_reg;
        oaddr_next      = oaddr_reg;
        odata_next      = odata_reg;
        obytes_next     = obytes_reg;
        orow_end_next   = orow_end_reg;
        oglyph_end_next = oglyph_end_reg;
        if (emit)
        begin
            ovalid_next     = 1'b1;
            oaddr_next      = addr_reg;
            odata_next      = bits_reg[ROW_BITS-1] ? pack_color(cfg.pixel_format, cfg.fg_color)
                                                   : pack_color(cfg.pixel_format, cfg.bg_color);
            obytes_next     = bpp;
            orow_end_next   = last_pix;
            oglyph_end_next = last_pix && last_row_reg;
        end
        else if (out_free)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            busy_reg   <= busy_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        bits_reg       <= bits_next;
        cnt_reg        <= cnt_next;
        wm1_reg        <= wm1_next;
        last_row_reg   <= last_row_next;
        oaddr_reg      <= oaddr_next;
        odata_reg      <= odata_next;
        obytes_reg     <= obytes_next;
        orow_end_reg   <= orow_end_next;
        oglyph_end_reg <= oglyph_end_next;
    end

    assign pix_valid     = ovalid_reg;
    assign pixel_address = 32'(oaddr_reg);
    assign pixel_data    = odata_reg;
    assign byte_count    = obytes_reg;
    assign row_end       = orow_end_reg;
    assign glyph_end     = oglyph_end_reg;

endmodule

/* rtl/mono_glyph_color_expand.sv */
// With the back end idle, the first pixel of a row is registered in the queue, then in the back
// end's row registers, then in its output stage, once its item beat is accepted.
// Throughput: one pixel per cycle on the output while pix_stall is low; a row has glyph_width
// pixels (1..16). The front takes one row per cycle into a 4-entry queue while the queue is
// not full, so rows go back to back with no gap between them.
// Reset: config returns to its defaults, queue and output stage empty, front row state zero.
module mono_glyph_color_expand
    import mgce_pkg::*;
#(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                first_row,
    input  logic [11:0]         dest_x,
    input  logic [11:0]         dest_y,
    input  logic [ROW_BITS-1:0] row_bits,
    output logic                pix_valid,
    input  logic                pix_stall,
    output logic [31:0]         pixel_address,
    output logic [23:0]         pixel_data,
    output logic [1:0]          byte_count,
    output logic                row_end,
    output logic                glyph_end
);

    `include "mono_glyph_color_expand_assert.svh"

    cfg_t cfg_reg, cfg_next;

    q_status_t               q_status;
    logic                    push;
    logic [ADDRESS_BITS-1:0] push_addr;
    row_info_t               push_info;
    logic                    pop;
    logic [ADDRESS_BITS-1:0] head_addr;
    row_info_t               head_info;

    logic                    pix_narrow;
    logic                    pix_332;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FG_COLOR:     cfg_next.fg_color     = cfg_data[23:0];
                REG_BG_COLOR:     cfg_next.bg_color     = cfg_data[23:0];
                REG_PIXEL_FORMAT: cfg_next.pixel_format = pix_fmt_t'(cfg_data[1:0]);
                REG_LINE_PITCH:   cfg_next.line_pitch   = cfg_data[14:0];
                REG_FRAME_BASE:   cfg_next.frame_base   = cfg_data;
                REG_GLYPH_WIDTH:  cfg_next.glyph_width  = cfg_data[4:0];
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = cfg_data[5:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fg_color     <= FG_RESET;
            cfg_reg.bg_color     <= BG_RESET;
            cfg_reg.pixel_format <= FMT_RGB888;
            cfg_reg.line_pitch   <= PITCH_RESET;
            cfg_reg.frame_base   <= BASE_RESET;
            cfg_reg.glyph_width  <= WIDTH_RESET;
            cfg_reg.glyph_height <= HEIGHT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mgce_front #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .first_row  (first_row),
        .dest_x     (dest_x),
        .dest_y     (dest_y),
        .row_bits   (row_bits),
        .q_status   (q_status),
        .push       (push),
        .push_addr  (push_addr),
        .push_info  (push_info)
    );

    mgce_queue #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_addr (push_addr),
        .push_info (push_info),
        .pop       (pop),
        .head_addr (head_addr),
        .head_info (head_info),
        .q_status  (q_status)
    );

    mgce_back #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_status      (q_status),
        .head_addr     (head_addr),
        .head_info     (head_info),
        .pop           (pop),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .pixel_address (pixel_address),
        .pixel_data    (pixel_data),
        .byte_count    (byte_count),
        .row_end       (row_end),
        .glyph_end     (glyph_end)
    );

    assign pix_narrow = pix_valid && byte_count != 2'd3;
    assign pix_332    = pix_valid && byte_count == 2'd1;

    // glyph end only ever lands on the last pixel of a row
    `MGCE_ASSERT_NOW(a_glyph_end_on_row_end, clk, rst_n, pix_valid && glyph_end, row_end)
    // narrow formats never carry the top byte
    `MGCE_ASSERT_NOW(a_narrow_top_zero, clk, rst_n, pix_narrow, pixel_data[23:16] == 8'h0)
    // RGB332 mode packs red 3, green 2, blue 2 bits and leaves the spare bit and upper bytes clear
    `MGCE_ASSERT_NOW(a_332_clean, clk, rst_n, pix_332, pixel_data[23:8] == 16'h0 && !pixel_data[2])

endmodule

/* sim/tb.sv */
module tb;
    import mgce_pkg::*;

    localparam int RANDOM_ROWS = 140;
    localparam int QUIET_ROWS  = 115;
    localparam int IDLE_LIMIT  = 2000;

    typedef struct packed {
        logic [31:0] addr;
        logic [23:0] data;
        logic [1:0]  nbytes;
        logic        row_end;
        logic        glyph_end;
    } pixel_beat_t;

    // One step of the directed sequence: a register write or a glyph row.
    // Rows marked known carry the first pixel's address and color as typed in.
    typedef struct packed {
        logic        is_reg;
        cfg_reg_t    sel;
        logic [31:0] value;
        logic        first;
        logic [11:0] x;
        logic [11:0] y;
        logic [15:0] bits;
        logic        known;
        logic [31:0] k_addr;
        logic [23:0] k_data;
    } plan_row_t;

    localparam plan_row_t PLAN [43] = '{
        // reset settings: 24bpp, pitch 3072, white on black
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'ha500, 1'b1, 32'h0, 24'hffffff},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b1, 12'h000, 12'h000, 16'h0000, 1'b1, 32'h0, 24'h000000},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b1, 12'hfff, 12'hfff, 16'hffff, 1'b1,
          32'h00c023fd, 24'hffffff},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h8001, 1'b0, 32'h0, 24'h0},
        // zero width and height fall back to one
        '{1'b1, REG_GLYPH_WIDTH, 32'd0, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_GLYPH_HEIGHT, 32'd0, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_PIXEL_FORMAT, 32'(FMT_RGB332), 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b1, 12'd5, 12'd2, 16'h8000, 1'b1, 32'h1805, 24'h0000fb},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h0000, 1'b0, 32'h0, 24'h0},
        // oversized width and height saturate; zero pitch; address wraps past the top
        '{1'b1, REG_GLYPH_WIDTH, 32'd31, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_GLYPH_HEIGHT, 32'd63, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_PIXEL_FORMAT, 32'(FMT_RGB555), 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_LINE_PITCH, 32'd0, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_FRAME_BASE, 32'hfffffff0, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b1, 12'hfff, 12'hfff, 16'hffff, 1'b1, 32'h1fee, 24'h7fff},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h5555, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'haaaa, 1'b0, 32'h0, 24'h0},
        // 565, widest pitch, two-row glyph then a row past the glyph end
        '{1'b1, REG_PIXEL_FORMAT, 32'(FMT_RGB565), 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_LINE_PITCH, 32'h7fff, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_FRAME_BASE, 32'h0, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_GLYPH_HEIGHT, 32'd2, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_GLYPH_WIDTH, 32'd16, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_FG_COLOR, 32'h123456, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_BG_COLOR, 32'hfedcba, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b1, 12'h001, 12'h001, 16'h0001, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h8000, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'hffff, 1'b0, 32'h0, 24'h0},
        // tall glyph, then the height shrinks below the current row
        '{1'b1, REG_GLYPH_HEIGHT, 32'd32, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_LINE_PITCH, 32'd1, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_GLYPH_WIDTH, 32'd9, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_PIXEL_FORMAT, 32'(FMT_RGB888), 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b1, 12'h000, 12'h000, 16'h1234, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h4321, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h0f0f, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'hf0f0, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h0ff0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_GLYPH_HEIGHT, 32'd3, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'h00ff, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'hff00, 1'b0, 32'h0, 24'h0},
        // black on white
        '{1'b1, REG_FG_COLOR, 32'h0, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b1, REG_BG_COLOR, 32'hffffff, 1'b0, 12'h0, 12'h0, 16'h0, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b1, 12'h800, 12'h400, 16'h0000, 1'b0, 32'h0, 24'h0},
        '{1'b0, REG_FG_COLOR, 32'h0, 1'b0, 12'h000, 12'h000, 16'hffff, 1'b0, 32'h0, 24'h0}
    };

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        item_valid;
    logic        item_stall;
    logic        first_row;
    logic [11:0] dest_x;
    logic [11:0] dest_y;
    logic [15:0] row_bits;
    logic        pix_valid;
    logic        pix_stall;
    logic [31:0] pixel_address;
    logic [23:0] pixel_data;
    logic [1:0]  byte_count;
    logic        row_end;
    logic        glyph_end;

    mono_glyph_color_expand uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .first_row     (first_row),
        .dest_x        (dest_x),
        .dest_y        (dest_y),
        .row_bits      (row_bits),
        .pix_valid     (pix_valid),
        .pix_stall     (pix_stall),
        .pixel_address (pixel_address),
        .pixel_data    (pixel_data),
        .byte_count    (byte_count),
        .row_end       (row_end),
        .glyph_end     (glyph_end)
    );

    // shadow copy of the registers and the row state
    logic [23:0] cur_fg;
    logic [23:0] cur_bg;
    pix_fmt_t    cur_fmt;
    logic [14:0] cur_pitch;
    logic [31:0] cur_base;
    logic [4:0]  cur_width;
    logic [5:0]  cur_height;
    logic [31:0] next_row_addr;
    logic [4:0]  next_row_idx;

    pixel_beat_t pending_pixels [$];
    pixel_beat_t want;

    int mismatches;
    int rows_sent;
    int pixels_checked;
    int glyph_ends;
    int reg_writes;
    int idle_cycles;
    int gap_odds;
    int stall_odds;
    int stall_left;
    int rand_rows;
    int quota;
    int glyph_len;
    int h_eff;
    int r;
    logic [3:0]  fmt_seen;
    logic        reg_burst;
    logic [31:0] reg_val;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        mismatches++;
        $display("mismatch at pixel beat %0d: %s got %h expected %h",
                 pixels_checked, what, got, exp_val);
    endtask

    function automatic logic [23:0] pack_rgb(input pix_fmt_t f, input logic [23:0] c);
        case (f)
            FMT_RGB332: return ((c >> 16) & 24'h0000e0) | ((c >> 11) & 24'h000018)
                             | ((c >> 6) & 24'h000003);
            FMT_RGB555: return ((c >> 9) & 24'h007c00) | ((c >> 6) & 24'h0003e0)
                             | ((c >> 3) & 24'h00001f);
            FMT_RGB565: return ((c >> 8) & 24'h00f800) | ((c >> 5) & 24'h0007e0)
                             | ((c >> 3) & 24'h00001f);
            default:    return c;
        endcase
    endfunction

    function automatic logic [15:0] rand_bits();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Expected pixel writes for one accepted glyph row.
    task automatic expand_row(input logic first, input logic [11:0] x, input logic [11:0] y,
                              input logic [15:0] bits, input logic known,
                              input logic [31:0] k_addr, input logic [23:0] k_data);
        int          w;
        int          h;
        int          idx;
        logic [1:0]  step;
        logic [31:0] start;
        logic [31:0] addr;
        logic [23:0] fg_p;
        logic [23:0] bg_p;
        logic        last;
        pixel_beat_t beat;
        w = (cur_width == 0) ? 1 : (cur_width > 16) ? 16 : int'(cur_width);
        h = (cur_height == 0) ? 1 : (cur_height > 32) ? 32 : int'(cur_height);
        case (cur_fmt)
            FMT_RGB332: step = 2'd1;
            FMT_RGB888: step = 2'd3;
            default:    step = 2'd2;
        endcase
        if (first)
        begin
            start = cur_base + 32'(cur_pitch) * 32'(y) + 32'(step) * 32'(x);
            idx = 0;
        end
        else
        begin
            start = next_row_addr;
            idx = int'(next_row_idx);
        end
        last = (idx + 1 >= h);
        fg_p = pack_rgb(cur_fmt, cur_fg);
        bg_p = pack_rgb(cur_fmt, cur_bg);
        addr = start;
        for (int n = 0; n < w; n++)
        begin
            beat.addr      = addr;
            beat.data      = bits[15 - n] ? fg_p : bg_p;
            beat.nbytes    = step;
            beat.row_end   = (n == w - 1);
            beat.glyph_end = (n == w - 1) && last;
            if (known && n == 0)
            begin
                beat.addr = k_addr;
                beat.data = k_data;
            end
            pending_pixels.push_back(beat);
            addr = addr + 32'(step);
        end
        next_row_addr = start + 32'(cur_pitch);
        next_row_idx  = last ? 5'd0 : 5'(idx + 1);
        fmt_seen[cur_fmt] = 1'b1;
    endtask

    task automatic send_row(input logic first, input logic [11:0] x, input logic [11:0] y,
                            input logic [15:0] bits, input logic known,
                            input logic [31:0] k_addr, input logic [23:0] k_data);
        if (gap_odds != 0 && $urandom_range(0, 3 * gap_odds) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
        item_valid <= 1'b1;
        first_row  <= first;
        dest_x     <= x;
        dest_y     <= y;
        row_bits   <= bits;
        do @(posedge clk); while (item_stall);
        expand_row(first, x, y, bits, known, k_addr, k_data);
        rows_sent++;
        @(negedge clk);
    endtask

    // Let the block drain: every pending pixel out, then some idle slack.
    task automatic settle();
        item_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic cfg_write(input cfg_reg_t sel, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        case (sel)
            REG_FG_COLOR:     cur_fg     = value[23:0];
            REG_BG_COLOR:     cur_bg     = value[23:0];
            REG_PIXEL_FORMAT: cur_fmt    = pix_fmt_t'(value[1:0]);
            REG_LINE_PITCH:   cur_pitch  = value[14:0];
            REG_FRAME_BASE:   cur_base   = value;
            REG_GLYPH_WIDTH:  cur_width  = value[4:0];
            REG_GLYPH_HEIGHT: cur_height = value[5:0];
            default:          ;
        endcase
        reg_writes++;
        @(negedge clk);
    endtask

    // output side: random stall bursts
    initial
    begin
        pix_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
                stall_left--;
            else if (stall_odds != 0 && $urandom_range(0, 3 * stall_odds) == 0)
                stall_left = $urandom_range(1, 8);
            pix_stall <= (stall_left != 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_valid && !pix_stall)
        begin
            if (pending_pixels.size() == 0)
                report_mismatch("pixel beat with nothing pending, address",
                                pixel_address, 32'h0);
            else
            begin
                want = pending_pixels.pop_front();
                if (pixel_address !== want.addr)
                    report_mismatch("pixel_address", pixel_address, want.addr);
                if (pixel_data !== want.data)
                    report_mismatch("pixel_data", 32'(pixel_data), 32'(want.data));
                if (byte_count !== want.nbytes)
                    report_mismatch("byte_count", 32'(byte_count), 32'(want.nbytes));
                if (row_end !== want.row_end)
                    report_mismatch("row_end", 32'(row_end), 32'(want.row_end));
                if (glyph_end !== want.glyph_end)
                    report_mismatch("glyph_end", 32'(glyph_end), 32'(want.glyph_end));
                if (want.glyph_end)
                    glyph_ends++;
            end
            pixels_checked++;
        end
    end

    // watchdog: too long without any beat on any channel
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (pix_valid && !pix_stall) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: no progress for %0d cycles", IDLE_LIMIT);
            $display("tb failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = 3'd0;
        cfg_data       = 32'h0;
        item_valid     = 1'b0;
        first_row      = 1'b0;
        dest_x         = 12'h0;
        dest_y         = 12'h0;
        row_bits       = 16'h0;
        idle_cycles    = 0;
        mismatches     = 0;
        rows_sent      = 0;
        pixels_checked = 0;
        glyph_ends     = 0;
        reg_writes     = 0;
        fmt_seen       = 4'b0;
        reg_burst      = 1'b0;
        gap_odds       = 1;
        stall_odds     = 1;
        cur_fg         = FG_RESET;
        cur_bg         = BG_RESET;
        cur_fmt        = FMT_RGB888;
        cur_pitch      = PITCH_RESET;
        cur_base       = BASE_RESET;
        cur_width      = WIDTH_RESET;
        cur_height     = HEIGHT_RESET;
        next_row_addr  = 32'h0;
        next_row_idx   = 5'd0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (PLAN[i])
        begin
            if (PLAN[i].is_reg)
            begin
                if (!reg_burst)
                    settle();
                reg_burst = 1'b1;
                cfg_write(PLAN[i].sel, PLAN[i].value);
            end
            else
            begin
                if (reg_burst)
                    cfg_valid <= 1'b0;
                reg_burst = 1'b0;
                send_row(PLAN[i].first, PLAN[i].x, PLAN[i].y, PLAN[i].bits,
                         PLAN[i].known, PLAN[i].k_addr, PLAN[i].k_data);
            end
        end

        rand_rows = 0;
        while (rand_rows < RANDOM_ROWS)
        begin
            if (rand_rows >= QUIET_ROWS)
            begin
                gap_odds   = 0;
                stall_odds = 0;
            end
            else
            begin
                gap_odds   = $urandom_range(0, 4);
                stall_odds = $urandom_range(0, 4);
            end
            settle();
            for (r = 0; r < 7; r++)
            begin
                if (rows_sent < $size(PLAN) + 1 || $urandom_range(0, 1) == 1)
                begin
                    case (cfg_reg_t'(r))
                        REG_FG_COLOR, REG_BG_COLOR:
                            if ($urandom_range(0, 3) == 0)
                                reg_val = $urandom_range(0, 1) ? 32'hffffff : 32'h0;
                            else
                                reg_val = $urandom & 32'hffffff;
                        REG_PIXEL_FORMAT:
                            reg_val = $urandom_range(0, 3);
                        REG_LINE_PITCH:
                            case ($urandom_range(0, 5))
                                0:       reg_val = 32'd0;
                                1:       reg_val = 32'd1;
                                2:       reg_val = 32'h7fff;
                                3:       reg_val = 32'd16384;
                                default: reg_val = $urandom_range(1, 16384);
                            endcase
                        REG_FRAME_BASE:
                            case ($urandom_range(0, 3))
                                0:       reg_val = 32'h0;
                                1:       reg_val = 32'hffff0000 | $urandom_range(0, 65535);
                                default: reg_val = $urandom;
                            endcase
                        REG_GLYPH_WIDTH:
                            if ($urandom_range(0, 4) == 0)
                                case ($urandom_range(0, 3))
                                    0:       reg_val = 32'd0;
                                    1:       reg_val = 32'd16;
                                    2:       reg_val = 32'd17;
                                    default: reg_val = 32'd31;
                                endcase
                            else
                                reg_val = $urandom_range(1, 16);
                        default:
                            if ($urandom_range(0, 5) == 0)
                                case ($urandom_range(0, 3))
                                    0:       reg_val = 32'd0;
                                    1:       reg_val = 32'd32;
                                    2:       reg_val = 32'd33;
                                    default: reg_val = 32'd63;
                                endcase
                            else
                                reg_val = $urandom_range(1, 4);
                    endcase
                    cfg_write(cfg_reg_t'(r), reg_val);
                end
            end
            cfg_valid <= 1'b0;

            quota = rand_rows + $urandom_range(14, 22);
            while (rand_rows < quota)
            begin
                if ($urandom_range(0, 4) != 0)
                begin
                    // glyph from its first row: a first row, then continuation rows, sometimes cut short
                    h_eff = (cur_height == 0) ? 1 : (cur_height > 32) ? 32 : int'(cur_height);
                    if (h_eff <= 6 || $urandom_range(0, 2) == 0)
                        glyph_len = h_eff;
                    else
                        glyph_len = $urandom_range(1, h_eff);
                    for (int k = 0; k < glyph_len; k++)
                    begin
                        send_row(k == 0, 12'($urandom), 12'($urandom), rand_bits(),
                                 1'b0, 32'h0, 24'h0);
                        rand_rows++;
                    end
                end
                else
                begin
                    send_row(1'($urandom), 12'($urandom), 12'($urandom), rand_bits(),
                             1'b0, 32'h0, 24'h0);
                    rand_rows++;
                end
                if ($urandom_range(0, 39) == 0)
                    settle();
            end
        end

        item_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("tb: %0d glyph rows, %0d pixel beats checked, %0d glyph ends, %0d reg writes",
                 rows_sent, pixels_checked, glyph_ends, reg_writes);
        $display("tb: pixel formats hit (bit per format) %b, %0d mismatches",
                 fmt_seen, mismatches);
        if (mismatches == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mgce_pkg.sv
rtl/mgce_front.sv
rtl/mgce_queue.sv
rtl/mgce_back.sv
rtl/mono_glyph_color_expand.sv
sim/tb.sv
